// ===== src/vrf_pkg.sv =====
// Package for the VGA register file: port codes, controller states,
// command/status structs and write-mask functions. No dependencies.
`default_nettype none
package vrf_pkg;

  localparam int unsigned PalDepth  = 256;
  localparam int unsigned CrtcDepth = 256;

  localparam logic [15:0] PORT_ATTR    = 16'h03C0;
  localparam logic [15:0] PORT_ATTR_RD = 16'h03C1;
  localparam logic [15:0] PORT_MISC_WR = 16'h03C2;
  localparam logic [15:0] PORT_SEQ_IX  = 16'h03C4;
  localparam logic [15:0] PORT_SEQ_DT  = 16'h03C5;
  localparam logic [15:0] PORT_DAC_RD  = 16'h03C7;
  localparam logic [15:0] PORT_DAC_WR  = 16'h03C8;
  localparam logic [15:0] PORT_DAC_DT  = 16'h03C9;
  localparam logic [15:0] PORT_FEAT_RD = 16'h03CA;
  localparam logic [15:0] PORT_MISC_RD = 16'h03CC;
  localparam logic [15:0] PORT_GFX_IX  = 16'h03CE;
  localparam logic [15:0] PORT_GFX_DT  = 16'h03CF;
  localparam logic [15:0] PORT_CRT_IXM = 16'h03B4;
  localparam logic [15:0] PORT_CRT_DTM = 16'h03B5;
  localparam logic [15:0] PORT_STAT_M  = 16'h03BA;
  localparam logic [15:0] PORT_CRT_IXC = 16'h03D4;
  localparam logic [15:0] PORT_CRT_DTC = 16'h03D5;
  localparam logic [15:0] PORT_STAT_C  = 16'h03DA;

  localparam logic [7:0] RETRACE_TOGGLE = 8'h09;
  localparam logic [7:0] CR_LOCK_BIT    = 8'h80;
  localparam logic [7:0] CR_OVERFLOW    = 8'h07;
  localparam logic [7:0] CR_SYNC_END    = 8'h11;
  localparam logic [4:0] ATTR_COUNT     = 5'h15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_EXEC,
    ST_DONE
  } vrf_state_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic clear_en;  // clearing pass: write zero at clear address
    logic exec;      // perform the latched access
    logic finish;    // drive the result strobe
  } vrf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
  } vrf_status_t;

  function automatic logic [7:0] seq_mask(input logic [2:0] ix);
    unique case (ix)
      3'd0: seq_mask = 8'h03;
      3'd1: seq_mask = 8'h3d;
      3'd2: seq_mask = 8'h0f;
      3'd3: seq_mask = 8'h3f;
      3'd4: seq_mask = 8'h0e;
      3'd7: seq_mask = 8'hff;
      default: seq_mask = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] gfx_mask(input logic [3:0] ix);
    unique case (ix)
      4'd3: gfx_mask = 8'h1f;
      4'd4: gfx_mask = 8'h03;
      4'd5: gfx_mask = 8'h7b;
      4'd8: gfx_mask = 8'hff;
      4'd0, 4'd1, 4'd2, 4'd6, 4'd7: gfx_mask = 8'h0f;
      default: gfx_mask = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] attr_mask(input logic [4:0] ix);
    if (ix <= 5'h0f) attr_mask = 8'h3f;
    else if (ix == 5'h10) attr_mask = 8'hef;
    else if (ix == 5'h12) attr_mask = 8'h3f;
    else if (ix == 5'h13 || ix == 5'h14) attr_mask = 8'h0f;
    else attr_mask = 8'hff;
  endfunction

endpackage
`default_nettype wire

// ===== src/vrf_ctrl.sv =====
// Controller of the VGA register file: clearing pass after reset, then
// capture / execute / respond per item. Depends on vrf_pkg.
`default_nettype none
module vrf_ctrl import vrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  vrf_status_t      status,
  output logic             busy,
  output vrf_cmd_t         cmd
);

  vrf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_EXEC;
      ST_EXEC:  state_next = ST_DONE;
      ST_DONE:  state_next = start ? ST_EXEC : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clear_en = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        cmd.capture = start;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_DONE: begin
        busy = 1'b0;
        cmd.finish = 1'b1;
        cmd.capture = start;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/vrf_datapath.sv =====
// Datapath of the VGA register file: all register stores, CRTC and palette
// memories, port decode and the result register. Depends on vrf_pkg.
`default_nettype none
module vrf_datapath import vrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  vrf_cmd_t         cmd,
  input  wire logic        operation,
  input  wire logic [15:0] port_address,
  input  wire logic [7:0]  write_data,
  output vrf_status_t      status,
  output logic             done,
  output logic [7:0]       read_data
);

  localparam int unsigned AW = $clog2(PalDepth);

  // latched item
  logic        op_q;
  logic [15:0] port_q;
  logic [7:0]  wd_q;

  logic [5:0] attr_index;
  logic       attr_phase;
  logic [7:0] attr_regs [21];
  logic [7:0] misc_output, feature_control, status_one;
  logic [2:0] seq_index;
  logic [7:0] seq_regs [8];
  logic [3:0] gfx_index;
  logic [7:0] gfx_regs [16];
  logic [7:0] crtc_index;
  logic [7:0] cr11, cr7;
  logic [1:0] dac_mode, dac_sub;
  logic [AW-1:0] dac_rd_index, dac_wr_index;
  logic [7:0] dac_staging [2];
  logic [7:0] clr_addr;

  logic [7:0]  crtc_mem [CrtcDepth];
  logic [23:0] pal_mem [PalDepth];
  logic [7:0]  crtc_rd;
  logic [23:0] pal_rd;

  assign status.clear_last = (clr_addr == 8'hff);

  // result strobe in the done cycle
  assign done = cmd.finish;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      port_q <= port_address;
      wd_q   <= write_data;
    end
  end

  // alias check
  logic alias_bad;
  always_comb begin
    if (misc_output[0]) alias_bad = port_q[15:4] == 12'h03B;
    else                alias_bad = port_q[15:4] == 12'h03D;
  end

  logic [4:0] a5;
  logic [1:0] sub_s;
  logic       is_crt_dt, is_stat;
  assign a5 = attr_index[4:0];
  assign sub_s = (dac_sub > 2'd2) ? 2'd2 : dac_sub;
  assign is_crt_dt = (port_q == PORT_CRT_DTM) || (port_q == PORT_CRT_DTC);
  assign is_stat = (port_q == PORT_STAT_M) || (port_q == PORT_STAT_C);

  logic wr_ok, rd_ok;
  assign wr_ok = cmd.exec && op_q && !alias_bad;
  assign rd_ok = cmd.exec && !op_q && !alias_bad;

  // CRTC write value with the CR0-7 lock
  logic       crt_we;
  logic [7:0] crt_wv;
  always_comb begin
    crt_we = wr_ok && is_crt_dt;
    crt_wv = wd_q;
    if (cr11[7] && crtc_index <= CR_OVERFLOW) begin
      crt_we = wr_ok && is_crt_dt && crtc_index == CR_OVERFLOW;
      crt_wv = (cr7 & 8'hef) | (wd_q & 8'h10);
    end
  end

  // memories: CRTC and palette, with clearing pass after reset
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      crtc_mem[clr_addr] <= '0;
      pal_mem[clr_addr[AW-1:0]] <= '0;
    end else begin
      if (crt_we) crtc_mem[crtc_index] <= crt_wv;
      if (wr_ok && port_q == PORT_DAC_DT && sub_s == 2'd2)
        pal_mem[dac_wr_index] <= {wd_q, dac_staging[1], dac_staging[0]};
    end
    crtc_rd <= crtc_mem[crtc_index];
    pal_rd  <= pal_mem[dac_rd_index];
  end

  // control and register state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      attr_index <= '0; attr_phase <= 1'b0;
      for (int i = 0; i < 21; i++) attr_regs[i] <= '0;
      misc_output <= '0; feature_control <= '0; status_one <= '0;
      seq_index <= '0;
      for (int i = 0; i < 8; i++) seq_regs[i] <= '0;
      gfx_index <= '0;
      for (int i = 0; i < 16; i++) gfx_regs[i] <= '0;
      crtc_index <= '0; cr11 <= '0; cr7 <= '0;
      dac_mode <= '0; dac_sub <= '0; dac_rd_index <= '0; dac_wr_index <= '0;
      dac_staging[0] <= '0; dac_staging[1] <= '0;
      read_data <= '0;
    end else begin
      if (cmd.clear_en) clr_addr <= clr_addr + 8'd1;
      if (crt_we && crtc_index == CR_SYNC_END) cr11 <= crt_wv;
      if (crt_we && crtc_index == CR_OVERFLOW) cr7 <= crt_wv;
      // writes return zero, reads in the disabled alias range return 0xff
      if (cmd.exec && (op_q || alias_bad))
        read_data <= (alias_bad && !op_q) ? 8'hff : 8'h00;
      if (wr_ok) begin
        priority case (1'b1)
          port_q == PORT_ATTR: begin
            if (!attr_phase) attr_index <= wd_q[5:0];
            else if (a5 < ATTR_COUNT) attr_regs[a5] <= wd_q & attr_mask(a5);
            attr_phase <= ~attr_phase;
          end
          port_q == PORT_MISC_WR: misc_output <= wd_q & 8'hef;
          port_q == PORT_SEQ_IX:  seq_index <= wd_q[2:0];
          port_q == PORT_SEQ_DT:  seq_regs[seq_index] <= wd_q & seq_mask(seq_index);
          port_q == PORT_DAC_RD: begin
            dac_rd_index <= wd_q[AW-1:0]; dac_sub <= '0; dac_mode <= 2'd3;
          end
          port_q == PORT_DAC_WR: begin
            dac_wr_index <= wd_q[AW-1:0]; dac_sub <= '0; dac_mode <= 2'd0;
          end
          port_q == PORT_DAC_DT: begin
            if (sub_s == 2'd2) begin
              dac_sub <= '0;
              dac_wr_index <= dac_wr_index + AW'(1);
            end else begin
              dac_staging[sub_s[0]] <= wd_q;
              dac_sub <= sub_s + 2'd1;
            end
          end
          port_q == PORT_GFX_IX: gfx_index <= wd_q[3:0];
          port_q == PORT_GFX_DT: gfx_regs[gfx_index] <= wd_q & gfx_mask(gfx_index);
          port_q == PORT_CRT_IXM || port_q == PORT_CRT_IXC: crtc_index <= wd_q;
          is_stat: feature_control <= wd_q & 8'h10;
          default: ;
        endcase
      end
      if (rd_ok) begin
        priority case (1'b1)
          port_q == PORT_ATTR: read_data <= attr_phase ? 8'h00 : {2'b00, attr_index};
          port_q == PORT_ATTR_RD:
            read_data <= (a5 < ATTR_COUNT) ? attr_regs[a5] : 8'h00;
          port_q == PORT_SEQ_IX: read_data <= {5'd0, seq_index};
          port_q == PORT_SEQ_DT: read_data <= seq_regs[seq_index];
          port_q == PORT_DAC_RD: read_data <= {6'd0, dac_mode};
          port_q == PORT_DAC_WR: read_data <= 8'(dac_wr_index);
          port_q == PORT_DAC_DT: begin
            read_data <= pal_rd[8*sub_s +: 8];
            if (sub_s == 2'd2) begin
              dac_sub <= '0;
              dac_rd_index <= dac_rd_index + AW'(1);
            end else begin
              dac_sub <= sub_s + 2'd1;
            end
          end
          port_q == PORT_FEAT_RD: read_data <= feature_control;
          port_q == PORT_MISC_RD: read_data <= misc_output;
          port_q == PORT_GFX_IX:  read_data <= {4'd0, gfx_index};
          port_q == PORT_GFX_DT:  read_data <= gfx_regs[gfx_index];
          port_q == PORT_CRT_IXM || port_q == PORT_CRT_IXC: read_data <= crtc_index;
          is_crt_dt: read_data <= crtc_rd;
          is_stat: begin
            status_one <= status_one ^ RETRACE_TOGGLE;
            read_data <= status_one ^ RETRACE_TOGGLE;
            attr_phase <= 1'b0;
          end
          default: read_data <= 8'h00;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/vga_register_file.sv =====
// VGA register file top level: controller plus datapath.
// Depends on vrf_pkg, vrf_ctrl and vrf_datapath.
//
// Usage: raise start with operation, port_address and write_data while busy
// is low; the item is taken at that clock edge. After the execute state, done is
// high for exactly one cycle and read_data holds the read byte (0xff for a read
// in the disabled mono/color alias range, zero on writes). The receiver cannot
// stall; read_data keeps the result until the next item executes.
// The execute state uses the registered data of the synchronous reads of the
// CRTC and palette memories. busy is low in the done cycle, so a new item may
// be taken there.
// Reset: synchronous rst resets the controller and the register state, then a
// clearing pass zeroes every entry of the CRTC and palette memories, one entry
// each per cycle; busy stays high through it.
`default_nettype none
module vga_register_file import vrf_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        operation,
  input  wire logic [15:0] port_address,
  input  wire logic [7:0]  write_data,
  output logic             done,
  output logic [7:0]       read_data
);

  vrf_cmd_t    cmd;
  vrf_status_t status;

  vrf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .status(status),
    .busy(busy), .cmd(cmd)
  );

  vrf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .operation(operation),
    .port_address(port_address), .write_data(write_data),
    .status(status), .done(done), .read_data(read_data)
  );

endmodule
`default_nettype wire
